// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/core/tri2x_pkg.sv
// ----------------------------------------------------------------------------
// tri2x_pkg
// Constants and types of the streaming 2x trilinear volume upsampler.
// ----------------------------------------------------------------------------
package tri2x_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int MAX_PAGES   = 1024;
    localparam int MAX_SERIES  = 1024;
    localparam int SAMPLE_BITS = 16;

    // Counter widths.
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int PAGE_W   = $clog2(MAX_PAGES);
    localparam int SERIES_W = $clog2(MAX_SERIES);

    // Configuration register widths.
    localparam int RSIZE_W = 7;
    localparam int CSIZE_W = 7;
    localparam int PSIZE_W = 11;
    localparam int SSIZE_W = 11;
    localparam int CFG_W   = 11;
    localparam int SIZE_W  = 11;

    // Result widths: three fraction bits on the value, doubled coordinates.
    localparam int VALUE_W = SAMPLE_BITS + 3;
    localparam int PAIR_W  = SAMPLE_BITS + 1;
    localparam int OROW_W  = ROW_W + 1;
    localparam int OCOL_W  = COL_W + 1;
    localparam int OPAGE_W = PAGE_W + 1;

    // Plane store: two planes split by column parity into four banks.
    localparam int N_BANKS    = 4;
    localparam int BANK_DEPTH = MAX_ROWS * MAX_COLS / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam int N_POINTS = 8;

    localparam logic [SIZE_W-1:0] RESET_ROWS   = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] RESET_COLS   = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] RESET_PAGES  = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] RESET_SERIES = SIZE_W'(1);

    typedef enum logic [1:0] {
        CFG_ROWS_IN   = 2'd0,
        CFG_COLS_IN   = 2'd1,
        CFG_PAGES_IN  = 2'd2,
        CFG_SERIES_IN = 2'd3
    } t_cfg_idx;

endpackage

// File: rtl/core/trilinear_2x_volume_upsampler.sv
// Each input voxel causes one to eight result transfers (eight for an interior
// voxel, fewer on the first row, column or page). The result port moves one
// per cycle while i_stall is low, and voxels that cause a single result stream
// at one per cycle while i_stall is low. The first result of a voxel is
// presented from stage C once the voxel has passed stage B, where it waits
// while stage C still holds results. The plane store is four single-read banks,
// so the three neighbors from the previous column and the previous page are
// read together; the other four come from the previous voxel.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
// trilinear_2x_volume_upsampler
// Streaming 2x trilinear upsampler with plane stores and a result sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trilinear_2x_volume_upsampler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_wr_en,
    input  logic [1:0]                           i_cfg_idx,
    input  logic [tri2x_pkg::CFG_W-1:0]          i_cfg_data,
    // input voxels
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [tri2x_pkg::SAMPLE_BITS-1:0]    i_sample,
    // results
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [tri2x_pkg::VALUE_W-1:0]        o_value,
    output logic [tri2x_pkg::OROW_W-1:0]         o_out_row,
    output logic [tri2x_pkg::OCOL_W-1:0]         o_out_col,
    output logic [tri2x_pkg::OPAGE_W-1:0]        o_out_page,
    output logic [tri2x_pkg::SERIES_W-1:0]       o_out_series,
    output logic                                 o_last
);

    localparam int ROW_W    = tri2x_pkg::ROW_W;
    localparam int COL_W    = tri2x_pkg::COL_W;
    localparam int PAGE_W   = tri2x_pkg::PAGE_W;
    localparam int SERIES_W = tri2x_pkg::SERIES_W;
    localparam int SIZE_W   = tri2x_pkg::SIZE_W;
    localparam int SB       = tri2x_pkg::SAMPLE_BITS;
    localparam int VALUE_W  = tri2x_pkg::VALUE_W;
    localparam int PAIR_W   = tri2x_pkg::PAIR_W;
    localparam int NP       = tri2x_pkg::N_POINTS;
    localparam int NB       = tri2x_pkg::N_BANKS;
    localparam int BANK_AW  = tri2x_pkg::BANK_AW;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                      input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [tri2x_pkg::RSIZE_W-1:0] r_rows_in;
    logic [tri2x_pkg::CSIZE_W-1:0] r_cols_in;
    logic [tri2x_pkg::PSIZE_W-1:0] r_pages_in;
    logic [tri2x_pkg::SSIZE_W-1:0] r_series_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in   <= tri2x_pkg::RSIZE_W'(tri2x_pkg::RESET_ROWS);
            r_cols_in   <= tri2x_pkg::CSIZE_W'(tri2x_pkg::RESET_COLS);
            r_pages_in  <= tri2x_pkg::PSIZE_W'(tri2x_pkg::RESET_PAGES);
            r_series_in <= tri2x_pkg::SSIZE_W'(tri2x_pkg::RESET_SERIES);
        end else if (i_cfg_wr_en) begin
            unique case (tri2x_pkg::t_cfg_idx'(i_cfg_idx))
                tri2x_pkg::CFG_ROWS_IN: begin
                    r_rows_in <= i_cfg_data[tri2x_pkg::RSIZE_W-1:0];
                end
                tri2x_pkg::CFG_COLS_IN: begin
                    r_cols_in <= i_cfg_data[tri2x_pkg::CSIZE_W-1:0];
                end
                tri2x_pkg::CFG_PAGES_IN: begin
                    r_pages_in <= i_cfg_data[tri2x_pkg::PSIZE_W-1:0];
                end
                tri2x_pkg::CFG_SERIES_IN: begin
                    r_series_in <= i_cfg_data[tri2x_pkg::SSIZE_W-1:0];
                end
            endcase
        end
    end

    logic [SIZE_W-1:0] nr, nc, np, ns;
    assign nr = clamp_size(SIZE_W'(r_rows_in),   SIZE_W'(tri2x_pkg::MAX_ROWS));
    assign nc = clamp_size(SIZE_W'(r_cols_in),   SIZE_W'(tri2x_pkg::MAX_COLS));
    assign np = clamp_size(SIZE_W'(r_pages_in),  SIZE_W'(tri2x_pkg::MAX_PAGES));
    assign ns = clamp_size(SIZE_W'(r_series_in), SIZE_W'(tri2x_pkg::MAX_SERIES));

    // ------------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------------
    logic              r_b_valid;
    logic [NP-1:0]     r_c_mask;
    logic              a_fire, b_adv, c_free, out_fire, out_last;

    assign o_valid  = (r_c_mask != '0);
    assign out_fire = o_valid && !i_stall;
    assign out_last = ((r_c_mask & (r_c_mask - NP'(1))) == '0);
    assign c_free   = !o_valid || (out_fire && out_last);
    assign b_adv    = r_b_valid && c_free;
    assign o_stall  = r_b_valid && !b_adv;
    assign a_fire   = i_valid && !o_stall;

    // ------------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------------
    logic [ROW_W-1:0]    r_row_cnt,    n_row_cnt;
    logic [COL_W-1:0]    r_col_cnt,    n_col_cnt;
    logic [PAGE_W-1:0]   r_page_cnt,   n_page_cnt;
    logic [SERIES_W-1:0] r_series_cnt, n_series_cnt;

    always_comb begin
        n_row_cnt    = r_row_cnt;
        n_col_cnt    = r_col_cnt;
        n_page_cnt   = r_page_cnt;
        n_series_cnt = r_series_cnt;
        if (SIZE_W'(r_row_cnt) + SIZE_W'(1) >= nr) begin
            n_row_cnt = '0;
            if (SIZE_W'(r_col_cnt) + SIZE_W'(1) >= nc) begin
                n_col_cnt = '0;
                if (SIZE_W'(r_page_cnt) + SIZE_W'(1) >= np) begin
                    n_page_cnt = '0;
                    if (SIZE_W'(r_series_cnt) + SIZE_W'(1) >= ns) begin
                        n_series_cnt = '0;
                    end else begin
                        n_series_cnt = r_series_cnt + SERIES_W'(1);
                    end
                end else begin
                    n_page_cnt = r_page_cnt + PAGE_W'(1);
                end
            end else begin
                n_col_cnt = r_col_cnt + COL_W'(1);
            end
        end else begin
            n_row_cnt = r_row_cnt + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt    <= '0;
            r_col_cnt    <= '0;
            r_page_cnt   <= '0;
            r_series_cnt <= '0;
        end else if (a_fire) begin
            r_row_cnt    <= n_row_cnt;
            r_col_cnt    <= n_col_cnt;
            r_page_cnt   <= n_page_cnt;
            r_series_cnt <= n_series_cnt;
        end
    end

    // ------------------------------------------------------------------------
    // Plane store banks, indexed by {page parity, column parity}. The voxel is
    // written to its own bank while the other three are read: same column and
    // previous column of the previous page, and previous column of this page.
    // ------------------------------------------------------------------------
    logic [COL_W-1:0]   col_m1;
    logic [BANK_AW-1:0] addr_same, addr_prev;
    logic [1:0]         wr_bank;
    logic [SB-1:0]      rd_q [NB];

    assign col_m1    = r_col_cnt - COL_W'(1);
    assign addr_same = {r_col_cnt[COL_W-1:1], r_row_cnt};
    assign addr_prev = {col_m1[COL_W-1:1], r_row_cnt};
    assign wr_bank   = {r_page_cnt[0], r_col_cnt[0]};

    for (genvar g = 0; g < NB; g++) begin : g_bank
        logic [1:0] bank_id;
        assign bank_id = 2'(g);

        tri2x_ram #(
            .WIDTH (SB),
            .DEPTH (tri2x_pkg::BANK_DEPTH)
        ) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (a_fire && (bank_id == wr_bank)),
            .i_wr_addr (addr_same),
            .i_wr_data (i_sample),
            .i_rd_en   (a_fire),
            .i_rd_addr ((bank_id[0] == r_col_cnt[0]) ? addr_same : addr_prev),
            .o_rd_data (rd_q[g])
        );
    end

    // ------------------------------------------------------------------------
    // Stage B: store data arrives; corner sums of all eight points.
    // ------------------------------------------------------------------------
    logic [SB-1:0]       r_b_sample;
    logic [ROW_W-1:0]    r_b_row;
    logic [COL_W-1:0]    r_b_col;
    logic [PAGE_W-1:0]   r_b_page;
    logic [SERIES_W-1:0] r_b_series;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_fire) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_sample <= i_sample;
            r_b_row    <= r_row_cnt;
            r_b_col    <= r_col_cnt;
            r_b_page   <= r_page_cnt;
            r_b_series <= r_series_cnt;
        end
    end

    // Corner values of the current voxel: q_cp is column c-1 of this page,
    // q_pc page p-1 same column, q_pp page p-1 column c-1.
    logic [SB-1:0] q_cp, q_pc, q_pp;
    assign q_cp = rd_q[{r_b_page[0], ~r_b_col[0]}];
    assign q_pc = rd_q[{~r_b_page[0], r_b_col[0]}];
    assign q_pp = rd_q[{~r_b_page[0], ~r_b_col[0]}];

    // The previous voxel sits one row lower in the same column and page
    // whenever the row is not zero, so its corners are the row r-1 corners.
    logic [SB-1:0] r_prv_sample, r_prv_cp, r_prv_pc, r_prv_pp;

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_prv_sample <= r_b_sample;
            r_prv_cp     <= q_cp;
            r_prv_pc     <= q_pc;
            r_prv_pp     <= q_pp;
        end
    end

    logic [PAIR_W-1:0]  e00, e10, e01, e11;
    logic [VALUE_W-1:0] pt_val [NP];
    logic [NP-1:0]      pt_mask;

    assign e00 = PAIR_W'(r_b_sample) + PAIR_W'(r_prv_sample);
    assign e10 = PAIR_W'(q_cp) + PAIR_W'(r_prv_cp);
    assign e01 = PAIR_W'(q_pc) + PAIR_W'(r_prv_pc);
    assign e11 = PAIR_W'(q_pp) + PAIR_W'(r_prv_pp);

    // Point code {d, b, a}: offsets along page, column and row.
    always_comb begin
        logic [2:0]         code;
        logic [PAIR_W-1:0]  t00, t10, t01, t11;
        logic [VALUE_W-1:0] sum;
        logic [1:0]         cnt;
        for (int k = 0; k < NP; k++) begin
            code = 3'(k);
            t00  = code[0] ? e00 : PAIR_W'(r_b_sample);
            t10  = code[0] ? e10 : PAIR_W'(q_cp);
            t01  = code[0] ? e01 : PAIR_W'(q_pc);
            t11  = code[0] ? e11 : PAIR_W'(q_pp);
            sum  = VALUE_W'(t00)
                 + (code[1] ? VALUE_W'(t10) : '0)
                 + (code[2] ? VALUE_W'(t01) : '0)
                 + ((code[1] && code[2]) ? VALUE_W'(t11) : '0);
            cnt  = 2'(code[0]) + 2'(code[1]) + 2'(code[2]);
            pt_val[k]  = sum << (2'd3 - cnt);
            pt_mask[k] = !(code[0] && (r_b_row == '0))
                      && !(code[1] && (r_b_col == '0))
                      && !(code[2] && (r_b_page == '0));
        end
    end

    // ------------------------------------------------------------------------
    // Stage C: result sequencer, highest point code first.
    // ------------------------------------------------------------------------
    logic [VALUE_W-1:0]  r_c_val [NP];
    logic [ROW_W-1:0]    r_c_row;
    logic [COL_W-1:0]    r_c_col;
    logic [PAGE_W-1:0]   r_c_page;
    logic [SERIES_W-1:0] r_c_series;
    logic [2:0]          sel;

    always_comb begin
        sel = '0;
        for (int k = 0; k < NP; k++) begin
            if (r_c_mask[k]) begin
                sel = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_mask <= '0;
        end else if (b_adv) begin
            r_c_mask <= pt_mask;
        end else if (out_fire) begin
            r_c_mask[sel] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_c_val    <= pt_val;
            r_c_row    <= r_b_row;
            r_c_col    <= r_b_col;
            r_c_page   <= r_b_page;
            r_c_series <= r_b_series;
        end
    end

    assign o_value      = r_c_val[sel];
    assign o_out_row    = {r_c_row, 1'b0} - tri2x_pkg::OROW_W'(sel[0]);
    assign o_out_col    = {r_c_col, 1'b0} - tri2x_pkg::OCOL_W'(sel[1]);
    assign o_out_page   = {r_c_page, 1'b0} - tri2x_pkg::OPAGE_W'(sel[2]);
    assign o_out_series = r_c_series;
    assign o_last       = out_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_CLK(a_vertex_loaded, b_adv |=> r_c_mask[0], "vertex point missing from a voxel")
    `ASSERT_CLK(a_burst_holds, (out_fire && !o_last) |=> o_valid, "result burst broke off early")
    `ASSERT_NEVER(a_no_overrun, a_fire && r_b_valid && !b_adv, "voxel transfer overran stage B")

endmodule

// File: rtl/core/tri2x_ram.sv
// ----------------------------------------------------------------------------
// tri2x_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tri2x_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x trilinear volume upsampler. Whole volumes of
// voxels are streamed under a series of size settings while both sides of the
// stream pause at random. A scoreboard keeps its own plane store and position
// counters, predicts every interpolated point, and checks each result field.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [tri2x_pkg::VALUE_W-1:0]  value;
    logic [tri2x_pkg::OROW_W-1:0]   row;
    logic [tri2x_pkg::OCOL_W-1:0]   col;
    logic [tri2x_pkg::OPAGE_W-1:0]  page;
    logic [tri2x_pkg::SERIES_W-1:0] series;
    logic                           last;
} t_grid_point;

class volume_scoreboard;
    logic [tri2x_pkg::SAMPLE_BITS-1:0] planes [2][tri2x_pkg::MAX_COLS][tri2x_pkg::MAX_ROWS];
    logic [tri2x_pkg::SAMPLE_BITS-1:0] prior_voxel;
    int unsigned row_pos, col_pos, page_pos, series_pos;
    int unsigned size_rows, size_cols, size_pages, size_series;
    t_grid_point expected_points[$];

    function new();
        prior_voxel = '0;
        row_pos     = 0;
        col_pos     = 0;
        page_pos    = 0;
        series_pos  = 0;
        size_rows   = tri2x_pkg::RESET_ROWS;
        size_cols   = tri2x_pkg::RESET_COLS;
        size_pages  = tri2x_pkg::RESET_PAGES;
        size_series = tri2x_pkg::RESET_SERIES;
    endfunction

    function void set_size(tri2x_pkg::t_cfg_idx idx, logic [tri2x_pkg::CFG_W-1:0] data);
        case (idx)
            tri2x_pkg::CFG_ROWS_IN:   size_rows   = data[tri2x_pkg::RSIZE_W-1:0];
            tri2x_pkg::CFG_COLS_IN:   size_cols   = data[tri2x_pkg::CSIZE_W-1:0];
            tri2x_pkg::CFG_PAGES_IN:  size_pages  = data[tri2x_pkg::PSIZE_W-1:0];
            tri2x_pkg::CFG_SERIES_IN: size_series = data[tri2x_pkg::SSIZE_W-1:0];
            default: ;
        endcase
    endfunction

    // A zero size counts as one; sizes above the limit saturate.
    function int unsigned effective_size(int unsigned raw, int unsigned limit);
        if (raw == 0)
            return 1;
        return (raw > limit) ? limit : raw;
    endfunction

    function int unsigned pending();
        return expected_points.size();
    endfunction

    // Predicts every point that the arrival of one voxel completes.
    function void note_voxel(logic [tri2x_pkg::SAMPLE_BITS-1:0] voxel);
        int unsigned nr, nc, np, ns, r, c, p, sum;
        t_grid_point pt;
        t_grid_point batch[$];
        r  = row_pos;
        c  = col_pos;
        p  = page_pos;
        nr = effective_size(size_rows, tri2x_pkg::MAX_ROWS);
        nc = effective_size(size_cols, tri2x_pkg::MAX_COLS);
        np = effective_size(size_pages, tri2x_pkg::MAX_PAGES);
        ns = effective_size(size_series, tri2x_pkg::MAX_SERIES);
        planes[p % 2][c][r] = voxel;

        for (int d = 1; d >= 0; d--) begin
            if (d == 1 && p == 0)
                continue;
            for (int b = 1; b >= 0; b--) begin
                if (b == 1 && c == 0)
                    continue;
                for (int a = 1; a >= 0; a--) begin
                    if (a == 1 && r == 0)
                        continue;
                    sum = 0;
                    for (int dd = 0; dd <= d; dd++)
                        for (int db = 0; db <= b; db++)
                            for (int da = 0; da <= a; da++) begin
                                // The row neighbor of the same column is the voxel just before.
                                if (da == 1 && db == 0 && dd == 0)
                                    sum += prior_voxel;
                                else
                                    sum += planes[(p - dd) % 2][c - db][r - da];
                            end
                    pt.value  = tri2x_pkg::VALUE_W'(sum << (3 - (a + b + d)));
                    pt.row    = tri2x_pkg::OROW_W'(2 * r - a);
                    pt.col    = tri2x_pkg::OCOL_W'(2 * c - b);
                    pt.page   = tri2x_pkg::OPAGE_W'(2 * p - d);
                    pt.series = tri2x_pkg::SERIES_W'(series_pos);
                    pt.last   = 1'b0;
                    batch.push_back(pt);
                end
            end
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_points.push_back(batch[i]);

        prior_voxel = voxel;
        if (r + 1 >= nr) begin
            row_pos = 0;
            if (c + 1 >= nc) begin
                col_pos = 0;
                if (p + 1 >= np) begin
                    page_pos   = 0;
                    series_pos = (series_pos + 1 >= ns) ? 0 : series_pos + 1;
                end else begin
                    page_pos = p + 1;
                end
            end else begin
                col_pos = c + 1;
            end
        end else begin
            row_pos = r + 1;
        end
    endfunction

    // Compares a result with the oldest prediction; why lists the wrong fields.
    function bit check_point(t_grid_point got, output string why);
        t_grid_point want;
        want = expected_points.pop_front();
        why  = "";
        if (got.value !== want.value)
            why = {why, $sformatf(" value %0d want %0d", got.value, want.value)};
        if (got.row !== want.row)
            why = {why, $sformatf(" row %0d want %0d", got.row, want.row)};
        if (got.col !== want.col)
            why = {why, $sformatf(" col %0d want %0d", got.col, want.col)};
        if (got.page !== want.page)
            why = {why, $sformatf(" page %0d want %0d", got.page, want.page)};
        if (got.series !== want.series)
            why = {why, $sformatf(" series %0d want %0d", got.series, want.series)};
        if (got.last !== want.last)
            why = {why, $sformatf(" last %0b want %0b", got.last, want.last)};
        if (why != "")
            why = {$sformatf(" at (%0d,%0d,%0d,%0d):", want.row, want.col, want.page,
                             want.series), why};
        return why == "";
    endfunction
endclass

module tb;

    localparam int          RANDOM_ITEMS = 40;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned MAX_GAP      = 19;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_wr_en;
    logic [1:0]                           i_cfg_idx;
    logic [tri2x_pkg::CFG_W-1:0]          i_cfg_data;
    logic                                 i_valid;
    logic                                 o_stall;
    logic [tri2x_pkg::SAMPLE_BITS-1:0]    i_sample;
    logic                                 o_valid;
    logic                                 i_stall;
    logic [tri2x_pkg::VALUE_W-1:0]        o_value;
    logic [tri2x_pkg::OROW_W-1:0]         o_out_row;
    logic [tri2x_pkg::OCOL_W-1:0]         o_out_col;
    logic [tri2x_pkg::OPAGE_W-1:0]        o_out_page;
    logic [tri2x_pkg::SERIES_W-1:0]       o_out_series;
    logic                                 o_last;

    volume_scoreboard sb;
    int               mismatches;
    int unsigned      tx_calm;
    int unsigned      rx_calm;
    bit               hold_pending;

    trilinear_2x_volume_upsampler dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_page   (o_out_page),
        .o_out_series (o_out_series),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string why);
        mismatches++;
        $display("[%0t] mismatch:%s", $time, why);
    endtask

    // Random pause length, with occasional runs of back-to-back transfers.
    function automatic int unsigned pick_gap(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [tri2x_pkg::SAMPLE_BITS-1:0] pick_voxel();
        case ($urandom_range(0, 7))
            0, 1:    return '1;
            2:       return '0;
            default: return tri2x_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_voxel(input logic [tri2x_pkg::SAMPLE_BITS-1:0] voxel);
        int unsigned gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= voxel;
        do @(posedge i_clk); while (o_stall);
        sb.note_voxel(voxel);
    endtask

    task automatic send_random_voxels(input int unsigned count);
        repeat (count) send_voxel(pick_voxel());
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Writes all four size registers, one per clock edge.
    task automatic program_sizes(input logic [tri2x_pkg::CFG_W-1:0] rows,
                                 input logic [tri2x_pkg::CFG_W-1:0] cols,
                                 input logic [tri2x_pkg::CFG_W-1:0] pages,
                                 input logic [tri2x_pkg::CFG_W-1:0] series);
        tri2x_pkg::t_cfg_idx         order [4];
        logic [tri2x_pkg::CFG_W-1:0] data  [4];
        order = '{tri2x_pkg::CFG_ROWS_IN, tri2x_pkg::CFG_COLS_IN,
                  tri2x_pkg::CFG_PAGES_IN, tri2x_pkg::CFG_SERIES_IN};
        data  = '{rows, cols, pages, series};
        for (int i = 0; i < 4; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_idx   <= order[i];
            i_cfg_data  <= data[i];
            @(posedge i_clk);
            sb.set_size(order[i], data[i]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic take_result();
        t_grid_point got;
        string       why;
        got.value  = o_value;
        got.row    = o_out_row;
        got.col    = o_out_col;
        got.page   = o_out_page;
        got.series = o_out_series;
        got.last   = o_last;
        if (sb.pending() == 0)
            report_mismatch($sformatf(" unexpected result (%0d,%0d,%0d,%0d) value %0d",
                                      got.row, got.col, got.page, got.series, got.value));
        else if (!sb.check_point(got, why))
            report_mismatch(why);
    endtask

    // Result side: pauses at random, once for a long stretch to back up the block.
    initial begin
        int unsigned gap;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                gap = pick_gap(rx_calm);
                if (gap > 0) begin
                    i_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            take_result();
        end
    end

    initial begin
        int unsigned random_sent;
        int unsigned rows, cols, pages, series, volumes, lo;
        logic [tri2x_pkg::SAMPLE_BITS-1:0] mixed [6];
        sb           = new();
        mismatches   = 0;
        tx_calm      = 0;
        rx_calm      = 0;
        hold_pending = 1'b0;
        random_sent  = 0;
        mixed        = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE};
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_idx   <= tri2x_pkg::CFG_ROWS_IN;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Three voxels under the reset sizes, then the row size drops to the
        // current row position in the middle of the volume; the volume of full
        // scale voxels finishes as 3 x 2 x 2 and reaches the largest value.
        repeat (3) send_voxel('1);
        i_valid <= 1'b0;
        wait_drained();
        program_sizes({4'b1010, 7'd3}, 11'd2, 11'd2, 11'd0);
        repeat (10) send_voxel('1);
        i_valid <= 1'b0;
        wait_drained();

        // Zero sizes count as one: a column of pages, two volumes.
        program_sizes(11'd0, {4'b1111, 7'd0}, 11'd3, 11'd2);
        foreach (mixed[i])
            send_voxel(mixed[i]);
        i_valid <= 1'b0;
        wait_drained();

        // Small random volumes; the first one is large enough to fill the
        // block during a long result hold.
        while (random_sent < RANDOM_ITEMS) begin
            lo      = (random_sent == 0) ? 3 : 1;
            rows    = (lo == 1 && $urandom_range(0, 7) == 0) ? 0 : $urandom_range(lo, 4);
            cols    = (lo == 1 && $urandom_range(0, 7) == 0) ? 0 : $urandom_range(lo, 4);
            pages   = (lo == 1 && $urandom_range(0, 7) == 0) ? 0
                    : $urandom_range(lo > 1 ? 2 : 1, 2);
            series  = $urandom_range(0, 3);
            volumes = $urandom_range(1, 2);
            program_sizes({4'($urandom), 7'(rows)}, {4'($urandom), 7'(cols)},
                          11'(pages), 11'(series));
            if (random_sent == 0)
                hold_pending = 1'b1;
            rows  = (rows == 0) ? 1 : rows;
            cols  = (cols == 0) ? 1 : cols;
            pages = (pages == 0) ? 1 : pages;
            send_random_voxels(rows * cols * pages * volumes);
            random_sent += rows * cols * pages * volumes;
            wait_drained();
        end

        // Rows above the limit saturate; the run goes two voxels past one
        // full row so that the wrap shows.
        program_sizes(11'h7FF, 11'd1, 11'd1, 11'd1);
        send_random_voxels(tri2x_pkg::MAX_ROWS + 2);
        wait_drained();

        // Single voxel volumes move the series position to three.
        program_sizes(11'd1, 11'd1, 11'd1, 11'd4);
        send_random_voxels(3);
        wait_drained();

        // Series position now lies beyond the new series count and must wrap.
        program_sizes(11'd2, 11'd2, 11'd2, 11'd2);
        send_random_voxels(16);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
